// ===== sv/pffr_pkg.sv =====
// Shared widths, codes and controller/datapath signal groups for the page fault frame replacer.
`timescale 1ns / 1ps
`default_nettype none
package pffr_pkg;

    localparam int PAGE_W     = 10;
    localparam int RND_W      = 16;
    localparam int ACT_W      = 2;
    localparam int FRAME_W    = 6;
    localparam int FAULT_W    = 32;
    localparam int COUNT_W    = 7;
    localparam int PERM_W     = 2;
    localparam int ENTRY_W    = PERM_W + FRAME_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam int DEF_NUM_PAGES  = 1024;
    localparam int DEF_NUM_FRAMES = 64;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    // Remainder unit: bits of the random value handled per cycle.
    localparam int MOD_DIGIT = 4;
    localparam int MOD_STEPS = RND_W / MOD_DIGIT;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GRANT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd2;

    localparam logic [PERM_W-1:0] PERM_NONE = 2'd0;
    localparam logic [PERM_W-1:0] PERM_RO   = 2'd1;
    localparam logic [PERM_W-1:0] PERM_RW   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

    localparam logic MODE_FIFO   = 1'b0;
    localparam logic MODE_RANDOM = 1'b1;

    typedef struct packed {
        logic ready;
        logic accept;
        logic clr_write;
        logic grant;
        logic pick;
        logic evict_read;
        logic evict_clear;
        logic map;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic              clr_last;
        logic              in_range;
        logic [PERM_W-1:0] perm;
        logic              need_mod;
        logic              mod_done;
        logic              evict;
        logic              out_busy;
    } ctl_status_t;

endpackage
`default_nettype wire

// ===== sv/pffr_ifs.sv =====
// Handshake channels for fault items in and result items out.
`timescale 1ns / 1ps
`default_nettype none
interface pffr_in_if
    import pffr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page;
    logic [RND_W-1:0]  random_value;

    modport source (output valid, output page, output random_value, input ready);
    modport sink (input valid, input page, input random_value, output ready);
endinterface

interface pffr_out_if
    import pffr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [FRAME_W-1:0] frame;
    logic               evict_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic               write_back;
    logic [FAULT_W-1:0] fault_total;

    modport source (output valid, output action, output frame, output evict_valid,
                    output evicted_page, output write_back, output fault_total,
                    input ready);
    modport sink (input valid, input action, input frame, input evict_valid,
                  input evicted_page, input write_back, input fault_total,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/pffr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pffr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/pffr_ctrl.sv =====
// Controller state machine that sequences table accesses for each fault item.
`timescale 1ns / 1ps
`default_nettype none
module pffr_ctrl
    import pffr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire ctl_status_t st,
    output ctl_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_PICK,
        S_OWNER,
        S_EVICT,
        S_MAP,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ready  = ready_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (!st.in_range || st.perm[1])
                begin
                    state_next = S_EMIT;
                end
                else if (st.perm == PERM_RO)
                begin
                    cmd.grant  = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (!st.need_mod || st.mod_done)
                begin
                    cmd.pick   = 1'b1;
                    state_next = S_OWNER;
                end
            end
            S_OWNER:
            begin
                if (st.evict)
                begin
                    cmd.evict_read = 1'b1;
                    state_next     = S_EVICT;
                end
                else
                begin
                    state_next = S_MAP;
                end
            end
            S_EVICT:
            begin
                cmd.evict_clear = 1'b1;
                state_next      = S_MAP;
            end
            S_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!st.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/pffr_dp.sv =====
// Datapath: page and frame-owner tables, victim choice, remainder unit and result register.
`timescale 1ns / 1ps
`default_nettype none
module pffr_dp
    import pffr_pkg::*;
#(
    parameter int NUM_PAGES  = DEF_NUM_PAGES,
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [PAGE_W-1:0]     page,
    input  wire logic [RND_W-1:0]      random_value,
    input  wire ctl_cmd_t              cmd,
    output ctl_status_t                st,
    pffr_out_if.source                 result
);

    localparam int PAGE_AW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int FRAME_AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

    // Configuration
    logic               mode_reg, mode_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // Architectural state
    logic [COUNT_W-1:0] used_reg, used_next;
    logic [COUNT_W-1:0] fifo_reg, fifo_next;
    logic [FAULT_W-1:0] fault_reg, fault_next;
    logic [PAGE_AW-1:0] clr_addr_reg, clr_addr_next;

    // Item in flight
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [COUNT_W-1:0] victim_reg, victim_next;
    logic               evict_reg, evict_next;
    logic [ACT_W-1:0]   act_reg, act_next;
    logic [FRAME_W-1:0] res_frame_reg, res_frame_next;
    logic [PAGE_W-1:0]  evp_reg, evp_next;
    logic               wb_reg, wb_next;

    // Remainder unit
    logic [RND_W-1:0]     shift_reg, shift_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic [COUNT_W-1:0]   rem_step;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]   out_act_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic               out_ev_reg;
    logic [PAGE_W-1:0]  out_evp_reg;
    logic               out_wb_reg;
    logic [FAULT_W-1:0] out_fault_reg;

    // Table ports
    logic               pt_we;
    logic [PAGE_AW-1:0] pt_waddr;
    logic [ENTRY_W-1:0] pt_wdata;
    logic [PAGE_AW-1:0] pt_raddr;
    logic [ENTRY_W-1:0] pt_rdata;
    logic [PAGE_W-1:0]  own_rdata;

    // Victim choice
    logic [COUNT_W-1:0] n_act;
    logic               free;
    logic [COUNT_W:0]   fifo_inc;
    logic [COUNT_W-1:0] fifo_victim;
    logic [COUNT_W-1:0] victim_comb;

    // A frame count of zero acts as one; counts above the frame store are clipped.
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_act = COUNT_W'(1);
        end
        else if (32'(count_reg) > NUM_FRAMES)
        begin
            n_act = COUNT_W'(NUM_FRAMES);
        end
        else
        begin
            n_act = count_reg;
        end
    end

    assign free     = used_reg < n_act;
    assign fifo_inc = {1'b0, fifo_reg} + 1'b1;

    always_comb
    begin
        if (fifo_inc >= {1'b0, n_act})
        begin
            fifo_victim = '0;
        end
        else
        begin
            fifo_victim = fifo_inc[COUNT_W-1:0];
        end
        if (free)
        begin
            victim_comb = used_reg;
        end
        else if (mode_reg == MODE_FIFO)
        begin
            victim_comb = fifo_victim;
        end
        else
        begin
            victim_comb = rem_reg;
        end
    end

    // Restoring remainder, one digit of the random value per cycle.
    always_comb
    begin
        logic [COUNT_W:0]   t;
        logic [COUNT_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < MOD_DIGIT; i++)
        begin
            t = {r, shift_reg[RND_W-1-i]};
            if (t >= {1'b0, n_act})
            begin
                t = t - {1'b0, n_act};
            end
            r = t[COUNT_W-1:0];
        end
        rem_step = r;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        fifo_next      = fifo_reg;
        fault_next     = fault_reg;
        clr_addr_next  = clr_addr_reg;
        page_next      = page_reg;
        victim_next    = victim_reg;
        evict_next     = evict_reg;
        act_next       = act_reg;
        res_frame_next = res_frame_reg;
        evp_next       = evp_reg;
        wb_next        = wb_reg;
        shift_next     = shift_reg;
        rem_next       = rem_reg;
        mod_cnt_next   = mod_cnt_reg;
        out_valid_next = out_valid_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:  mode_next  = cfg_data[0];
                CFG_COUNT: count_next = cfg_data[COUNT_W-1:0];
                default:   mode_next  = mode_reg;
            endcase
        end

        if (cmd.clr_write)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        if (mod_cnt_reg != MOD_CNT_W'(MOD_STEPS))
        begin
            shift_next   = shift_reg << MOD_DIGIT;
            rem_next     = rem_step;
            mod_cnt_next = mod_cnt_reg + 1'b1;
        end

        if (cmd.accept)
        begin
            page_next      = page;
            shift_next     = random_value;
            rem_next       = '0;
            mod_cnt_next   = '0;
            act_next       = ACT_NONE;
            res_frame_next = '0;
            evict_next     = 1'b0;
            evp_next       = '0;
            wb_next        = 1'b0;
        end

        if (cmd.grant)
        begin
            act_next       = ACT_GRANT;
            res_frame_next = pt_rdata[FRAME_W-1:0];
        end

        if (cmd.pick)
        begin
            victim_next = victim_comb;
            evict_next  = !free;
            fifo_next   = victim_comb;
            if (free)
            begin
                used_next = used_reg + 1'b1;
            end
            if (fault_reg != '1)
            begin
                fault_next = fault_reg + 1'b1;
            end
        end

        if (cmd.evict_read)
        begin
            evp_next = own_rdata;
        end

        if (cmd.evict_clear)
        begin
            wb_next = pt_rdata[ENTRY_W-1];
        end

        if (cmd.map)
        begin
            act_next       = ACT_LOAD;
            res_frame_next = victim_reg[FRAME_W-1:0];
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Page table: a single write per cycle and one registered read.
    always_comb
    begin
        pt_we    = 1'b0;
        pt_waddr = PAGE_AW'(page_reg);
        pt_wdata = '0;
        pt_raddr = PAGE_AW'(page_reg);
        if (cmd.clr_write)
        begin
            pt_we    = 1'b1;
            pt_waddr = clr_addr_reg;
        end
        else if (cmd.grant)
        begin
            pt_we    = 1'b1;
            pt_wdata = {PERM_RW, pt_rdata[FRAME_W-1:0]};
        end
        else if (cmd.evict_clear)
        begin
            pt_we    = 1'b1;
            pt_waddr = PAGE_AW'(evp_reg);
        end
        else if (cmd.map)
        begin
            pt_we    = 1'b1;
            pt_wdata = {PERM_RO, victim_reg[FRAME_W-1:0]};
        end
        if (cmd.accept)
        begin
            pt_raddr = PAGE_AW'(page);
        end
        else if (cmd.evict_read)
        begin
            pt_raddr = PAGE_AW'(own_rdata);
        end
    end

    pffr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_PAGES)
    ) u_page_tbl (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    // Frames below the fill count always have an owner, so no valid bits are kept.
    pffr_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_FRAMES)
    ) u_owner_tbl (
        .clk   (clk),
        .we    (cmd.map),
        .waddr (FRAME_AW'(victim_reg)),
        .wdata (page_reg),
        .raddr (FRAME_AW'(victim_comb)),
        .rdata (own_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_FIFO;
            count_reg     <= COUNT_RESET;
            used_reg      <= '0;
            fifo_reg      <= '0;
            fault_reg     <= '0;
            clr_addr_reg  <= '0;
            mod_cnt_reg   <= MOD_CNT_W'(MOD_STEPS);
            evict_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            fifo_reg      <= fifo_next;
            fault_reg     <= fault_next;
            clr_addr_reg  <= clr_addr_next;
            mod_cnt_reg   <= mod_cnt_next;
            evict_reg     <= evict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg      <= page_next;
        victim_reg    <= victim_next;
        act_reg       <= act_next;
        res_frame_reg <= res_frame_next;
        evp_reg       <= evp_next;
        wb_reg        <= wb_next;
        shift_reg     <= shift_next;
        rem_reg       <= rem_next;
        if (cmd.emit)
        begin
            out_act_reg   <= act_reg;
            out_frame_reg <= res_frame_reg;
            out_ev_reg    <= evict_reg && (act_reg == ACT_LOAD);
            out_evp_reg   <= evp_reg;
            out_wb_reg    <= wb_reg;
            out_fault_reg <= fault_reg;
        end
    end

    assign st.clr_last = (clr_addr_reg == PAGE_AW'(NUM_PAGES - 1));
    assign st.in_range = (32'(page_reg) < NUM_PAGES);
    assign st.perm     = pt_rdata[ENTRY_W-1 -: PERM_W];
    assign st.need_mod = !free && (mode_reg != MODE_FIFO);
    assign st.mod_done = (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS));
    assign st.evict    = evict_reg;
    assign st.out_busy = out_valid_reg && !result.ready;

    assign result.valid        = out_valid_reg;
    assign result.action       = out_act_reg;
    assign result.frame        = out_frame_reg;
    assign result.evict_valid  = out_ev_reg;
    assign result.evicted_page = out_evp_reg;
    assign result.write_back   = out_wb_reg;
    assign result.fault_total  = out_fault_reg;

endmodule
`default_nettype wire

// ===== sv/page_fault_frame_replacer.sv =====
// Top level of the page fault frame replacer: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none
// Takes one page fault item at a time and returns one result item for it. After reset the
// page table is swept clear, one entry a cycle, and no item is taken before the sweep ends;
// configuration writes are taken throughout. A no-op or a write-permission grant only looks
// the page up; a load into a free frame also picks and maps a frame, and a replacement also
// evicts the old owner, in random mode once the remainder is done. These steps follow from
// the page table (one write port, registered read), visited once to look the page up, once
// to read and once to clear the evicted page, and once to map the new one, and from the
// remainder unit that takes the random value apart four bits a cycle. The result waits in
// an output register, so a stalled sink holds the block only once the next result is ready.
module page_fault_frame_replacer
    import pffr_pkg::*;
#(
    parameter int NUM_PAGES  = DEF_NUM_PAGES,
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    pffr_in_if.sink                    fault,
    pffr_out_if.source                 result
);

    ctl_cmd_t    cmd;
    ctl_status_t st;

    pffr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (fault.valid),
        .st         (st),
        .cmd        (cmd)
    );

    pffr_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .page         (fault.page),
        .random_value (fault.random_value),
        .cmd          (cmd),
        .st           (st),
        .result       (result)
    );

    assign fault.ready = cmd.ready;

`ifndef NO_ASSERTIONS
    // Once an item is taken the block is busy with it and not ready in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !fault.ready)
        else $error("item taken while the previous one is still in work");

    // A write-back is only reported for an eviction caused by a load.
    a_wb_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.write_back) |->
            (result.evict_valid && (result.action == ACT_LOAD)))
        else $error("write-back without an eviction");

    // When nothing is done, the frame and eviction fields are all zero.
    a_none_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.action == ACT_NONE)) |->
            ((result.frame == '0) && !result.evict_valid &&
             (result.evicted_page == '0) && !result.write_back))
        else $error("no-op result carries frame or eviction data");
`endif

endmodule
`default_nettype wire
